### rtl/dms_pkg.sv
// ----------------------------------------------------------------------------
// Door motor sequencer package
// Shared widths, command codes, register indexes, result codes and the
// sequencer phase type.
// ----------------------------------------------------------------------------
package dms_pkg;

   localparam int CURRENT_BITS = 10;
   localparam int PWM_BITS     = 8;
   localparam int COUNT_BITS   = 20;
   localparam int DEAD_BITS    = 16;
   localparam int ADDR_BITS    = 5;
   localparam int DATA_BITS    = 32;
   localparam int INDEX_BITS   = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [PWM_BITS-1:0]     SPEED_RESET        = {PWM_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0]   TIMEOUT_RESET      = COUNT_BITS'(20000);
   localparam logic [CURRENT_BITS-1:0] LIMIT_RESET        = {CURRENT_BITS{1'b1}};
   localparam logic [DEAD_BITS-1:0]    RUN_DEAD_RESET     = DEAD_BITS'(500);
   localparam logic [DEAD_BITS-1:0]    FORCE_DEAD_RESET   = DEAD_BITS'(100);

   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_OPEN        = 3'd1,
      OP_CLOSE       = 3'd2,
      OP_FORCE_OPEN  = 3'd3,
      OP_FORCE_CLOSE = 3'd4,
      OP_STOP        = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_RUN_WAIT    = 3'd1,
      PH_RUN_DRIVE   = 3'd2,
      PH_FORCE_WAIT  = 3'd3,
      PH_FORCE_DRIVE = 3'd4
   } phase_type;

   localparam logic [INDEX_BITS-1:0] REG_MOTOR_SPEED    = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_TIMEOUT_TICKS  = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_CURRENT_LIMIT  = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_CURRENT_CHECK  = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_RUN_DEAD       = 3'd4;
   localparam logic [INDEX_BITS-1:0] REG_FORCE_DEAD     = 3'd5;
   localparam logic [INDEX_BITS-1:0] REG_SENSOR_LEVEL   = 3'd6;

   localparam logic [1:0] OUTCOME_NONE     = 2'd0;
   localparam logic [1:0] OUTCOME_SUCCESS  = 2'd1;
   localparam logic [1:0] OUTCOME_ALREADY  = 2'd2;
   localparam logic [1:0] OUTCOME_MISSED   = 2'd3;

   localparam logic [1:0] DOOR_CLOSED  = 2'd0;
   localparam logic [1:0] DOOR_OPEN    = 2'd1;
   localparam logic [1:0] DOOR_BETWEEN = 2'd2;
   localparam logic [1:0] DOOR_FAULT   = 2'd3;

endpackage

### rtl/door_motor_sequencer_top.sv
// ----------------------------------------------------------------------------
// Door motor sequencer
// Runs open, close and forced drive sequences of a two-direction door motor
// from one request per cycle while ready and reports drive levels and outcome.
// ----------------------------------------------------------------------------
// One request is taken per cycle while req_ready is high and gives exactly
// one response, valid in the cycle after. The whole sequencer step (command
// decode, dead-time count, end-of-run checks) is one pass of logic into the
// state and response registers. req_ready is high whenever the response
// register is empty or being taken in the same cycle. Registers are written
// through the APB port at byte address 4*index and read back there.
module door_motor_sequencer_top
   import dms_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_operation,
   input  logic                    req_open_switch,
   input  logic                    req_closed_switch,
   input  logic [CURRENT_BITS-1:0] req_motor_current,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [PWM_BITS-1:0]     rsp_drive_open,
   output logic [PWM_BITS-1:0]     rsp_drive_close,
   output logic [1:0]              rsp_door_state,
   output logic                    rsp_busy_res,
   output logic [1:0]              rsp_outcome,

   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [ADDR_BITS-1:0]    csr_paddr,
   input  logic [DATA_BITS-1:0]    csr_pwdata,
   output logic [DATA_BITS-1:0]    csr_prdata,
   output logic                    csr_pready
);

   logic [PWM_BITS-1:0]     motor_speed_ff;
   logic [COUNT_BITS-1:0]   timeout_ticks_ff;
   logic [CURRENT_BITS-1:0] current_limit_ff;
   logic                    current_check_ff;
   logic [DEAD_BITS-1:0]    run_dead_ff;
   logic [DEAD_BITS-1:0]    force_dead_ff;
   logic                    sensor_level_ff;

   phase_type               phase_ff, phase_in;
   logic                    direction_ff, direction_in;
   logic [COUNT_BITS-1:0]   tick_count_ff, tick_count_in;
   logic [PWM_BITS-1:0]     open_level_ff, open_level_in;
   logic [PWM_BITS-1:0]     close_level_ff, close_level_in;

   logic                    rsp_valid_ff;
   logic [PWM_BITS-1:0]     drive_open_ff;
   logic [PWM_BITS-1:0]     drive_close_ff;
   logic [1:0]              door_state_ff, door_state_in;
   logic                    busy_ff, busy_in;
   logic [1:0]              outcome_ff, outcome_in;

   logic                    req_fire;
   logic                    csr_write;
   logic [INDEX_BITS-1:0]   csr_index;
   logic                    open_act;
   logic                    closed_act;
   logic                    cmd_taken;
   logic                    refused;
   logic                    run_end;
   logic                    reached;
   logic                    over_current;
   logic [DEAD_BITS-1:0]    dead_ticks;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_fire   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[ADDR_BITS-1:2];

   assign open_act     = req_open_switch == sensor_level_ff;
   assign closed_act   = req_closed_switch == sensor_level_ff;
   assign over_current = current_check_ff && (req_motor_current >= current_limit_ff);
   assign cmd_taken    = (req_operation == OP_OPEN || req_operation == OP_CLOSE ||
                          req_operation == OP_FORCE_OPEN ||
                          req_operation == OP_FORCE_CLOSE) &&
                         (phase_ff == PH_IDLE || phase_ff == PH_FORCE_DRIVE);

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         motor_speed_ff   <= SPEED_RESET;
         timeout_ticks_ff <= TIMEOUT_RESET;
         current_limit_ff <= LIMIT_RESET;
         current_check_ff <= 1'b0;
         run_dead_ff      <= RUN_DEAD_RESET;
         force_dead_ff    <= FORCE_DEAD_RESET;
         sensor_level_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_MOTOR_SPEED:   motor_speed_ff   <= csr_pwdata[PWM_BITS-1:0];
            REG_TIMEOUT_TICKS: timeout_ticks_ff <= csr_pwdata[COUNT_BITS-1:0];
            REG_CURRENT_LIMIT: current_limit_ff <= csr_pwdata[CURRENT_BITS-1:0];
            REG_CURRENT_CHECK: current_check_ff <= csr_pwdata[0];
            REG_RUN_DEAD:      run_dead_ff      <= csr_pwdata[DEAD_BITS-1:0];
            REG_FORCE_DEAD:    force_dead_ff    <= csr_pwdata[DEAD_BITS-1:0];
            REG_SENSOR_LEVEL:  sensor_level_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MOTOR_SPEED:   csr_prdata = DATA_BITS'(motor_speed_ff);
         REG_TIMEOUT_TICKS: csr_prdata = DATA_BITS'(timeout_ticks_ff);
         REG_CURRENT_LIMIT: csr_prdata = DATA_BITS'(current_limit_ff);
         REG_CURRENT_CHECK: csr_prdata = DATA_BITS'(current_check_ff);
         REG_RUN_DEAD:      csr_prdata = DATA_BITS'(run_dead_ff);
         REG_FORCE_DEAD:    csr_prdata = DATA_BITS'(force_dead_ff);
         REG_SENSOR_LEVEL:  csr_prdata = DATA_BITS'(sensor_level_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      direction_in   = direction_ff;
      tick_count_in  = tick_count_ff;
      open_level_in  = open_level_ff;
      close_level_in = close_level_ff;
      refused        = 1'b0;
      run_end        = 1'b0;
      reached        = 1'b0;
      dead_ticks     = run_dead_ff;

      if (req_operation == OP_STOP) begin
         open_level_in  = '0;
         close_level_in = '0;
         phase_in       = PH_IDLE;
      end else if (cmd_taken) begin
         if (req_operation == OP_OPEN || req_operation == OP_CLOSE) begin
            if (req_operation == OP_OPEN) close_level_in = '0;
            else open_level_in = '0;
            if (req_operation == OP_OPEN ? open_act : closed_act) begin
               refused = 1'b1;
            end else begin
               direction_in  = req_operation == OP_CLOSE;
               tick_count_in = '0;
               phase_in      = PH_RUN_WAIT;
            end
         end else begin
            direction_in = req_operation == OP_FORCE_CLOSE;
            if (req_operation == OP_FORCE_OPEN) close_level_in = '0;
            else open_level_in = '0;
            tick_count_in = '0;
            phase_in      = PH_FORCE_WAIT;
         end
      end

      if (phase_in == PH_RUN_WAIT || phase_in == PH_FORCE_WAIT) begin
         dead_ticks = (phase_in == PH_RUN_WAIT) ? run_dead_ff : force_dead_ff;
         if (tick_count_in >= COUNT_BITS'(dead_ticks)) begin
            if (!direction_in) open_level_in = motor_speed_ff;
            else close_level_in = motor_speed_ff;
            tick_count_in = '0;
            phase_in = (phase_in == PH_RUN_WAIT) ? PH_RUN_DRIVE : PH_FORCE_DRIVE;
         end else begin
            tick_count_in = tick_count_in + 1'b1;
         end
      end

      if (phase_in == PH_RUN_DRIVE) begin
         reached = direction_in ? closed_act : open_act;
         if (reached || tick_count_in >= timeout_ticks_ff || over_current) begin
            if (!direction_in) open_level_in = '0;
            else close_level_in = '0;
            phase_in = PH_IDLE;
            run_end  = 1'b1;
         end else if (tick_count_in != COUNT_MAX) begin
            tick_count_in = tick_count_in + 1'b1;
         end
      end
   end

   // response fields
   always_comb begin
      priority if (refused) outcome_in = OUTCOME_ALREADY;
      else if (run_end)     outcome_in = reached ? OUTCOME_SUCCESS : OUTCOME_MISSED;
      else                  outcome_in = OUTCOME_NONE;

      unique case ({open_act, closed_act})
         2'b01:   door_state_in = DOOR_CLOSED;
         2'b10:   door_state_in = DOOR_OPEN;
         2'b00:   door_state_in = DOOR_BETWEEN;
         default: door_state_in = DOOR_FAULT;
      endcase

      busy_in = phase_in == PH_RUN_WAIT || phase_in == PH_RUN_DRIVE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         direction_ff   <= 1'b0;
         tick_count_ff  <= '0;
         open_level_ff  <= '0;
         close_level_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff       <= phase_in;
            direction_ff   <= direction_in;
            tick_count_ff  <= tick_count_in;
            open_level_ff  <= open_level_in;
            close_level_ff <= close_level_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         drive_open_ff  <= open_level_in;
         drive_close_ff <= close_level_in;
         door_state_ff  <= door_state_in;
         busy_ff        <= busy_in;
         outcome_ff     <= outcome_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_open  = drive_open_ff;
   assign rsp_drive_close = drive_close_ff;
   assign rsp_door_state  = door_state_ff;
   assign rsp_busy_res    = busy_ff;
   assign rsp_outcome     = outcome_ff;

endmodule

### sim/door_motor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Door motor sequencer checker
// Watches the request, response and register ports of the sequencer, keeps
// its own copy of the sequencer state and register settings, predicts one
// motor report per accepted request and compares each accepted response
// field by field against the oldest prediction. Register reads are checked
// against the register settings that it has seen written.
// ----------------------------------------------------------------------------
module door_motor_checker
   import dms_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [2:0]              req_operation,
   input  logic                    req_open_switch,
   input  logic                    req_closed_switch,
   input  logic [CURRENT_BITS-1:0] req_motor_current,

   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [PWM_BITS-1:0]     rsp_drive_open,
   input  logic [PWM_BITS-1:0]     rsp_drive_close,
   input  logic [1:0]              rsp_door_state,
   input  logic                    rsp_busy_res,
   input  logic [1:0]              rsp_outcome,

   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [ADDR_BITS-1:0]    csr_paddr,
   input  logic [DATA_BITS-1:0]    csr_pwdata,
   input  logic [DATA_BITS-1:0]    csr_prdata,
   input  logic                    csr_pready,

   output int                      mismatches,
   output int                      awaiting
);

   typedef struct packed {
      logic [PWM_BITS-1:0] drive_open;
      logic [PWM_BITS-1:0] drive_close;
      logic [1:0]          door_state;
      logic                busy;
      logic [1:0]          outcome;
   } motor_report_type;

   logic [PWM_BITS-1:0]     cfg_speed;
   logic [COUNT_BITS-1:0]   cfg_timeout;
   logic [CURRENT_BITS-1:0] cfg_limit;
   logic                    cfg_check;
   logic [DEAD_BITS-1:0]    cfg_run_dead;
   logic [DEAD_BITS-1:0]    cfg_force_dead;
   logic                    cfg_level;

   phase_type               seq_phase;
   logic                    seq_dir;
   logic [COUNT_BITS-1:0]   seq_count;
   logic [PWM_BITS-1:0]     open_level;
   logic [PWM_BITS-1:0]     close_level;

   motor_report_type        pending_reports[$];

   function automatic motor_report_type step_sequencer(
      input logic [2:0]              op,
      input logic                    osw,
      input logic                    csw,
      input logic [CURRENT_BITS-1:0] cur
   );
      logic                 open_hit;
      logic                 closed_hit;
      logic                 reached;
      logic                 over;
      logic [DEAD_BITS-1:0] dead;
      motor_report_type     r;
      open_hit   = (osw == cfg_level);
      closed_hit = (csw == cfg_level);
      r.outcome  = OUTCOME_NONE;

      if (op == OP_STOP) begin
         open_level  = '0;
         close_level = '0;
         seq_phase   = PH_IDLE;
      end else if ((op == OP_OPEN || op == OP_CLOSE || op == OP_FORCE_OPEN ||
                    op == OP_FORCE_CLOSE) &&
                   (seq_phase == PH_IDLE || seq_phase == PH_FORCE_DRIVE)) begin
         if (op == OP_OPEN || op == OP_FORCE_OPEN) close_level = '0;
         else open_level = '0;
         if (op == OP_OPEN || op == OP_CLOSE) begin
            if (op == OP_OPEN ? open_hit : closed_hit) begin
               r.outcome = OUTCOME_ALREADY;
            end else begin
               seq_dir   = (op == OP_CLOSE);
               seq_count = '0;
               seq_phase = PH_RUN_WAIT;
            end
         end else begin
            seq_dir   = (op == OP_FORCE_CLOSE);
            seq_count = '0;
            seq_phase = PH_FORCE_WAIT;
         end
      end

      if (seq_phase == PH_RUN_WAIT || seq_phase == PH_FORCE_WAIT) begin
         dead = (seq_phase == PH_RUN_WAIT) ? cfg_run_dead : cfg_force_dead;
         if (seq_count >= COUNT_BITS'(dead)) begin
            if (seq_dir) close_level = cfg_speed;
            else open_level = cfg_speed;
            seq_count = '0;
            seq_phase = (seq_phase == PH_RUN_WAIT) ? PH_RUN_DRIVE : PH_FORCE_DRIVE;
         end else begin
            seq_count++;
         end
      end

      if (seq_phase == PH_RUN_DRIVE) begin
         reached = seq_dir ? closed_hit : open_hit;
         over    = cfg_check && (cur >= cfg_limit);
         if (reached || seq_count >= cfg_timeout || over) begin
            if (seq_dir) close_level = '0;
            else open_level = '0;
            seq_phase = PH_IDLE;
            r.outcome = reached ? OUTCOME_SUCCESS : OUTCOME_MISSED;
         end else if (seq_count != COUNT_MAX) begin
            seq_count++;
         end
      end

      case ({open_hit, closed_hit})
         2'b01:   r.door_state = DOOR_CLOSED;
         2'b10:   r.door_state = DOOR_OPEN;
         2'b00:   r.door_state = DOOR_BETWEEN;
         default: r.door_state = DOOR_FAULT;
      endcase
      r.drive_open  = open_level;
      r.drive_close = close_level;
      r.busy        = (seq_phase == PH_RUN_WAIT || seq_phase == PH_RUN_DRIVE);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      motor_report_type     want;
      logic [DATA_BITS-1:0] reg_val;
      if (reset) begin
         mismatches     = 0;
         cfg_speed      = SPEED_RESET;
         cfg_timeout    = TIMEOUT_RESET;
         cfg_limit      = LIMIT_RESET;
         cfg_check      = 1'b0;
         cfg_run_dead   = RUN_DEAD_RESET;
         cfg_force_dead = FORCE_DEAD_RESET;
         cfg_level      = 1'b0;
         seq_phase      = PH_IDLE;
         seq_dir        = 1'b0;
         seq_count      = '0;
         open_level     = '0;
         close_level    = '0;
         pending_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[ADDR_BITS-1:2])
                  REG_MOTOR_SPEED:   cfg_speed      = csr_pwdata[PWM_BITS-1:0];
                  REG_TIMEOUT_TICKS: cfg_timeout    = csr_pwdata[COUNT_BITS-1:0];
                  REG_CURRENT_LIMIT: cfg_limit      = csr_pwdata[CURRENT_BITS-1:0];
                  REG_CURRENT_CHECK: cfg_check      = csr_pwdata[0];
                  REG_RUN_DEAD:      cfg_run_dead   = csr_pwdata[DEAD_BITS-1:0];
                  REG_FORCE_DEAD:    cfg_force_dead = csr_pwdata[DEAD_BITS-1:0];
                  REG_SENSOR_LEVEL:  cfg_level      = csr_pwdata[0];
                  default: ;
               endcase
            end else begin
               case (csr_paddr[ADDR_BITS-1:2])
                  REG_MOTOR_SPEED:   reg_val = DATA_BITS'(cfg_speed);
                  REG_TIMEOUT_TICKS: reg_val = DATA_BITS'(cfg_timeout);
                  REG_CURRENT_LIMIT: reg_val = DATA_BITS'(cfg_limit);
                  REG_CURRENT_CHECK: reg_val = DATA_BITS'(cfg_check);
                  REG_RUN_DEAD:      reg_val = DATA_BITS'(cfg_run_dead);
                  REG_FORCE_DEAD:    reg_val = DATA_BITS'(cfg_force_dead);
                  REG_SENSOR_LEVEL:  reg_val = DATA_BITS'(cfg_level);
                  default:           reg_val = '0;
               endcase
               check_field("prdata", reg_val, csr_prdata);
            end
         end

         if (req_valid && req_ready) begin
            pending_reports.push_back(step_sequencer(req_operation, req_open_switch,
                                                     req_closed_switch,
                                                     req_motor_current));
         end

         if (rsp_valid && rsp_ready) begin
            if (pending_reports.size() == 0) begin
               $error("response with no request outstanding");
               mismatches++;
            end else begin
               want = pending_reports.pop_front();
               check_field("drive_open", want.drive_open, rsp_drive_open);
               check_field("drive_close", want.drive_close, rsp_drive_close);
               check_field("door_state", want.door_state, rsp_door_state);
               check_field("busy_res", want.busy, rsp_busy_res);
               check_field("outcome", want.outcome, rsp_outcome);
            end
         end
      end
      awaiting = pending_reports.size();
   end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Door motor sequencer testbench
// Drives directed and randomized door episodes (open and close runs up to a
// limit switch, forced runs, stops, stray commands and noise) through the
// request port under several register settings, with random stalls on both
// sides; the verdict comes from the checker's mismatch and awaiting counts.
// ----------------------------------------------------------------------------
module tb;
   import dms_pkg::*;

   localparam logic [2:0] OP_UNUSED_LO = 3'd6;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;

   logic                    req_valid         = 1'b0;
   logic                    req_ready;
   logic [2:0]              req_operation     = OP_TICK;
   logic                    req_open_switch   = 1'b0;
   logic                    req_closed_switch = 1'b0;
   logic [CURRENT_BITS-1:0] req_motor_current = '0;

   logic                    rsp_valid;
   logic                    rsp_ready         = 1'b0;
   logic [PWM_BITS-1:0]     rsp_drive_open;
   logic [PWM_BITS-1:0]     rsp_drive_close;
   logic [1:0]              rsp_door_state;
   logic                    rsp_busy_res;
   logic [1:0]              rsp_outcome;

   logic                    csr_psel          = 1'b0;
   logic                    csr_penable       = 1'b0;
   logic                    csr_pwrite        = 1'b0;
   logic [ADDR_BITS-1:0]    csr_paddr         = '0;
   logic [DATA_BITS-1:0]    csr_pwdata        = '0;
   logic [DATA_BITS-1:0]    csr_prdata;
   logic                    csr_pready;

   int                      mismatches;
   int                      awaiting;

   bit                      steady            = 1'b0;
   logic                    level_set         = 1'b0;
   int                      run_dead_set      = 0;
   int                      force_dead_set    = 0;
   int                      timeout_set       = 0;

   door_motor_sequencer_top u_top (.*);

   door_motor_checker u_checker (.*);

   always #10 clock = ~clock;

   always @(negedge clock) rsp_ready <= steady || ($urandom_range(0, 99) >= 10);

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int capped(input int v);
      return (v > 60) ? 60 : v;
   endfunction

   function automatic logic switch_level(input logic hit);
      return hit ? level_set : ~level_set;
   endfunction

   function automatic logic [CURRENT_BITS-1:0] sample_current();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return CURRENT_BITS'((1 << CURRENT_BITS) - 1 - $urandom_range(0, 40));
      if (r < 15) return CURRENT_BITS'($urandom_range(0, (1 << CURRENT_BITS) - 1));
      return CURRENT_BITS'($urandom_range(0, 300));
   endfunction

   task automatic send_request(input logic [2:0] op, input logic osw, input logic csw,
                               input logic [CURRENT_BITS-1:0] cur);
      if (!steady) begin
         while ($urandom_range(0, 99) < 10) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_open_switch   <= osw;
      req_closed_switch <= csw;
      req_motor_current <= cur;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_position(input logic [2:0] op, input logic dir,
                                input logic target_hit, input logic other_hit);
      logic t_lvl;
      logic o_lvl;
      t_lvl = switch_level(target_hit);
      o_lvl = switch_level(other_hit);
      send_request(op, dir ? o_lvl : t_lvl, dir ? t_lvl : o_lvl, sample_current());
   endtask

   task automatic access_register(input logic wr, input logic [INDEX_BITS-1:0] idx,
                                  input logic [DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [PWM_BITS-1:0] speed,
                                input logic [COUNT_BITS-1:0] timeout,
                                input logic [CURRENT_BITS-1:0] limit,
                                input logic check,
                                input logic [DEAD_BITS-1:0] run_dead,
                                input logic [DEAD_BITS-1:0] force_dead,
                                input logic level);
      access_register(1'b1, REG_MOTOR_SPEED, DATA_BITS'(speed));
      access_register(1'b1, REG_TIMEOUT_TICKS, DATA_BITS'(timeout));
      access_register(1'b1, REG_CURRENT_LIMIT, DATA_BITS'(limit));
      access_register(1'b1, REG_CURRENT_CHECK, DATA_BITS'(check));
      access_register(1'b1, REG_RUN_DEAD, DATA_BITS'(run_dead));
      access_register(1'b1, REG_FORCE_DEAD, DATA_BITS'(force_dead));
      access_register(1'b1, REG_SENSOR_LEVEL, DATA_BITS'(level));
      for (int i = REG_MOTOR_SPEED; i <= REG_SENSOR_LEVEL; i++)
         access_register(1'b0, INDEX_BITS'(i), '0);
      level_set      = level;
      run_dead_set   = run_dead;
      force_dead_set = force_dead;
      timeout_set    = timeout;
   endtask

   task automatic door_episode(output int sent);
      int         pick;
      int         span;
      logic       dir;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      dir  = 1'($urandom_range(0, 1));
      sent = 0;
      if (pick < 60) begin
         // open or close run: leave the target switch, then reach it
         send_position(dir ? OP_CLOSE : OP_OPEN, dir, $urandom_range(0, 99) < 12,
                       1'($urandom_range(0, 1)));
         span = $urandom_range(0, capped(run_dead_set) + capped(timeout_set) + 2);
         for (int i = 0; i < span; i++) begin
            op = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(0, 7)) : OP_TICK;
            send_position(op, dir, 1'b0,
                          ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
         end
         send_position(OP_TICK, dir, 1'b1, 1'b0);
         sent = span + 2;
      end else if (pick < 85) begin
         send_request(dir ? OP_FORCE_CLOSE : OP_FORCE_OPEN, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), sample_current());
         span = $urandom_range(0, capped(force_dead_set) + 20);
         for (int i = 0; i < span; i++) begin
            op = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(0, 7)) : OP_TICK;
            send_request(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         sample_current());
         end
         sent = span + 1;
         if ($urandom_range(0, 99) < 70) begin
            send_request(OP_STOP, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         sample_current());
            sent++;
         end
      end else begin
         span = $urandom_range(1, 5);
         for (int i = 0; i < span; i++)
            send_request(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)),
                         CURRENT_BITS'($urandom_range(0, (1 << CURRENT_BITS) - 1)));
         sent = span;
      end
   endtask

   task automatic run_phase(input int items);
      int total;
      int n;
      total = 0;
      while (total < items) begin
         door_episode(n);
         total += n;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic on_lvl;
      logic off_lvl;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_settings(8'd255, 20'd5, 10'd1000, 1'b1, 16'd1, 16'd0, 1'b0);
      on_lvl  = switch_level(1'b1);
      off_lvl = switch_level(1'b0);
      send_request(OP_TICK, off_lvl, off_lvl, '0);
      send_request(OP_OPEN, on_lvl, off_lvl, '1);
      send_request(OP_CLOSE, off_lvl, on_lvl, '0);
      send_request(OP_OPEN, off_lvl, off_lvl, '0);
      send_request(OP_CLOSE, off_lvl, off_lvl, '0);
      send_request(OP_TICK, off_lvl, off_lvl, 10'd512);
      send_request(OP_TICK, on_lvl, off_lvl, '0);
      send_request(OP_CLOSE, off_lvl, off_lvl, '0);
      send_request(OP_TICK, off_lvl, off_lvl, '1);
      send_request(OP_FORCE_OPEN, off_lvl, off_lvl, '0);
      send_request(OP_TICK, on_lvl, on_lvl, '0);
      send_request(OP_FORCE_CLOSE, off_lvl, off_lvl, '0);
      send_request(OP_OPEN, off_lvl, off_lvl, '0);
      send_request(OP_STOP, off_lvl, off_lvl, '0);
      send_request(OP_CLOSE, off_lvl, off_lvl, '0);
      send_request(OP_UNUSED_LO, off_lvl, off_lvl, '0);
      send_request(OP_UNUSED_HI, off_lvl, off_lvl, '0);
      repeat (4) send_request(OP_TICK, off_lvl, off_lvl, '0);
      send_request(OP_FORCE_CLOSE, off_lvl, off_lvl, '0);
      send_request(OP_STOP, on_lvl, off_lvl, '1);
      send_request(OP_OPEN, off_lvl, off_lvl, '0);
      send_request(OP_TICK, off_lvl, off_lvl, '0);
      send_request(OP_STOP, off_lvl, off_lvl, '0);
      drain();

      load_settings('0, '0, '0, 1'b1, '0, '0, 1'b1);
      run_phase(200);
      drain();

      steady = 1'b1;
      load_settings('1, '1, '1, 1'b0, 16'd3, 16'd2, 1'b0);
      run_phase(300);
      drain();
      steady = 1'b0;

      load_settings(PWM_BITS'($urandom_range(0, 255)), COUNT_BITS'($urandom_range(5, 40)),
                    CURRENT_BITS'($urandom_range(600, 1023)), 1'b1,
                    DEAD_BITS'($urandom_range(0, 6)), DEAD_BITS'($urandom_range(0, 6)),
                    1'($urandom_range(0, 1)));
      run_phase(500);
      drain();

      load_settings(PWM_BITS'($urandom_range(0, 255)), 20'd20, 10'd800, 1'b1,
                    '1, '1, 1'b1);
      run_phase(100);
      drain();

      load_settings(PWM_BITS'($urandom_range(0, 255)), COUNT_BITS'($urandom_range(0, 15)),
                    CURRENT_BITS'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                    DEAD_BITS'($urandom_range(0, 4)), DEAD_BITS'($urandom_range(0, 4)),
                    1'b0);
      run_phase(300);
      drain();

      if (mismatches == 0 && awaiting == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
